FILE: sv/svtd_pkg.sv
// Shared types, constants and constant tables of the sine voice.
`default_nettype none

package svtd_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int REQ_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 16;
    localparam int A4_W     = 31;
    localparam int LEVEL_W  = VEL_W;
    localparam int TAIL_W   = 17;
    localparam int NOTES    = 1 << NOTE_W;
    localparam logic [A4_W-1:0] A4_RESET = 31'd39370534;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2
    } req_type_t;

    // sine table: one quarter wave; the peak entry at the quarter end is kept apart
    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int POS_W   = QB + 1;
    localparam int SIN_W   = 31;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // release tail, Q1.16
    localparam logic [TAIL_W-1:0] TAIL_ONE_Q16   = 17'h10000;
    localparam logic [TAIL_W-1:0] STOP_LEVEL_Q16 = 17'd327;
    localparam logic [15:0]       DECAY_Q16      = 16'd64881;

    // shared multiplier and accumulator widths
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = TAIL_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int LO_W    = 16;
    localparam int SL_W    = SIN_W + LEVEL_W;
    localparam int ACC_W   = SL_W + TAIL_W;
    // sine Q30, level 2^-18, tail Q16, then scale to Q1.(SAMPLE_BITS-1)
    localparam int ROUND_SH = 30 + 18 + 16 - (SAMPLE_BITS - 1);
    localparam logic [ACC_W:0] ROUND_HALF = {{ACC_W{1'b0}}, 1'b1} << (ROUND_SH - 1);
    localparam logic [ACC_W:0] MAG_MAX = ({{ACC_W{1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - 1'b1;

    // note step rounding
    localparam int NSTEP_W = MUL_P_W + 1;
    localparam int SHIFT_W = 5;

    localparam logic [16:0] SEMITONE_Q16 [12] = '{
        17'd65536,  17'd69433,  17'd73562,  17'd77936,  17'd82570,  17'd87480,
        17'd92682,  17'd98193,  17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    typedef logic [SIN_W-1:0]   sine_rom_t   [QUARTER];
    typedef logic [SHIFT_W-1:0] note_shift_t [NOTES];
    typedef logic [16:0]        note_ratio_t [NOTES];

    // odd Taylor series to degree 11, truncating Q2.30 steps
    function automatic logic [SIN_W-1:0] sine_entry(int p);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        a  = (64'(p) * HALF_PI_Q30) >> QB;
        a2 = (a * a) >> 30;
        t  = Q30_ONE - a2 / 110;
        t  = Q30_ONE - ((a2 * t) >> 30) / 72;
        t  = Q30_ONE - ((a2 * t) >> 30) / 42;
        t  = Q30_ONE - ((a2 * t) >> 30) / 20;
        t  = Q30_ONE - ((a2 * t) >> 30) / 6;
        s  = (a * t) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        return s[SIN_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int p = 0; p < QUARTER; p++) begin
            rom[p] = sine_entry(p);
        end
        return rom;
    endfunction

    // 22 - octave, with note 69 at octave 6 of the shifted scale
    function automatic note_shift_t build_note_shift();
        note_shift_t tab;
        int          nn;
        for (int n = 0; n < NOTES; n++) begin
            nn     = n + 3;
            tab[n] = SHIFT_W'(22 - nn / 12);
        end
        return tab;
    endfunction

    function automatic note_ratio_t build_note_ratio();
        note_ratio_t tab;
        int          nn;
        for (int n = 0; n < NOTES; n++) begin
            nn     = n + 3;
            tab[n] = SEMITONE_Q16[nn % 12];
        end
        return tab;
    endfunction

    localparam sine_rom_t        SINE_ROM   = build_sine_rom();
    localparam logic [SIN_W-1:0] SINE_PEAK  = sine_entry(QUARTER);
    localparam note_shift_t      NOTE_SHIFT = build_note_shift();
    localparam note_ratio_t      NOTE_RATIO = build_note_ratio();

    typedef enum logic [3:0] {
        U_NOP,
        U_SIN_RD,
        U_MUL_SL,
        U_LATCH_PROD,
        U_MUL_LO,
        U_MUL_HI,
        U_ACC_ADD,
        U_ROUND,
        U_DECAY,
        U_EMIT,
        U_ZERO,
        U_NOTE_MUL,
        U_NOTE_STEP,
        U_NOTE_OFF
    } uop_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_ALWAYS,
        C_SILENT,
        C_OUT_FULL
    } cond_t;

    localparam int PC_W        = 4;
    localparam int UCODE_DEPTH = 15;

    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] tgt;
        logic            last;
    } uword_t;

    typedef struct packed {
        logic silent;
        logic out_full;
    } seq_status_t;

    typedef struct packed {
        uop_t uop;
        logic busy;
    } seq_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/svtd_req_if.sv
// Request channel: tick, note-on and note-off items.
`default_nettype none

interface svtd_req_if;
    import svtd_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              allow_tail_off;

    modport source (output valid, req_type, note, velocity, allow_tail_off, input ready);
    modport sink   (input valid, req_type, note, velocity, allow_tail_off, output ready);
endinterface

`default_nettype wire

FILE: sv/svtd_smp_if.sv
// Sample channel: one output sample per tick.
`default_nettype none

interface svtd_smp_if;
    import svtd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          voice_active;

    modport source (output valid, sample, voice_active, input ready);
    modport sink   (input valid, sample, voice_active, output ready);
endinterface

`default_nettype wire

FILE: sv/svtd_cfg_if.sv
// Configuration write channel for the A4 phase increment.
`default_nettype none

interface svtd_cfg_if;
    import svtd_pkg::*;

    logic            valid;
    logic            ready;
    logic [A4_W-1:0] a4_phase_increment;

    modport source (output valid, a4_phase_increment, input ready);
    modport sink   (input valid, a4_phase_increment, output ready);
endinterface

`default_nettype wire

FILE: sv/sine_voice_with_tail_decay.sv
// Sine voice: phase accumulator oscillator with velocity level and exponential release.
//
// Channels: req carries one request (tick, note-on, note-off); smp returns one sample
// per tick; cfg writes the A4 phase increment (always ready, write only while idle).
// Each request runs as a short microprogram on one shared 31x17 multiplier:
//   tick        sine read, three products, round, decay and emit; a silent voice
//               skips to a zero sample
//   note-on      increment product, then round and saturate
//   note-off     starts the tail or silences the voice; an unknown request does nothing
// A new request is taken the cycle after the previous program ends, so no request is
// taken while a program runs; the chain of dependent products sets the tick length.
// The sample waits in an output register; a new request is taken while it waits, and a
// following tick holds just before its emit step until the receiver has taken the
// earlier one.
// Reset leaves the voice silent with phase, level and tail at zero and restores the A4
// increment to its default.
`default_nettype none

module sine_voice_with_tail_decay (
    input  wire      clk,
    input  wire      rst_n,
    svtd_cfg_if.sink cfg,
    svtd_req_if.sink req,
    svtd_smp_if.source smp
);
    import svtd_pkg::*;

    seq_ctrl_t   ctrl;
    seq_status_t status;
    logic        in_xfer;

    logic [A4_W-1:0]        a4_reg,         a4_next;
    logic [PHASE_BITS-1:0]  phase_reg,      phase_next;
    logic [PHASE_BITS-1:0]  step_reg,       step_next;
    logic [LEVEL_W-1:0]     level_reg,      level_next;
    logic [TAIL_W-1:0]      tail_reg,       tail_next;
    logic [NOTE_W-1:0]      note_reg,       note_next;
    logic [VEL_W-1:0]       vel_reg,        vel_next;
    logic                   allow_reg,      allow_next;
    logic [SIN_W-1:0]       sin_reg,        sin_next;
    logic                   neg_reg,        neg_next;
    logic [SL_W-1:0]        prod_reg,       prod_next;
    logic [MUL_P_W-1:0]     mul_reg,        mul_next;
    logic [ACC_W-1:0]       acc_reg,        acc_next;
    logic [SHIFT_W-1:0]     shift_reg,      shift_next;
    logic [SAMPLE_BITS-1:0] smp_val_reg,    smp_val_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   out_active_reg, out_active_next;
    logic                   out_valid_reg,  out_valid_next;

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [QB-1:0]              qpos;
    logic [POS_W-1:0]           pos;
    logic [TAIL_W-1:0]          tailx;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_P_W-1:0]         mul_prod;
    logic [ACC_W:0]             rnd;
    logic [ACC_W:0]             mag_full;
    logic [SAMPLE_BITS-1:0]     mag;
    logic [SAMPLE_BITS-1:0]     sample_val;
    logic [MUL_P_W-1:0]         dec_sum;
    logic [TAIL_W-1:0]          dec_tail;
    logic [NSTEP_W-1:0]         step_rnd;
    logic [NSTEP_W-1:0]         step_shr;
    logic [PHASE_BITS-1:0]      step_sat;

    svtd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .req_type (req.req_type),
        .status   (status),
        .ctrl     (ctrl)
    );

    assign req.ready = !ctrl.busy;
    assign cfg.ready = 1'b1;
    assign in_xfer   = req.valid && req.ready;

    assign status.silent   = (step_reg == '0);
    assign status.out_full = out_valid_reg && !smp.ready;

    assign smp.valid        = out_valid_reg;
    assign smp.sample       = $signed(out_sample_reg);
    assign smp.voice_active = out_active_reg;

    // quarter-wave folding of the table position
    assign idx  = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad = idx[SINE_TABLE_BITS-1 -: 2];
    assign qpos = idx[QB-1:0];
    assign pos  = quad[0] ? (POS_W'(QUARTER) - {1'b0, qpos}) : {1'b0, qpos};

    assign tailx = (tail_reg == '0) ? TAIL_ONE_Q16 : tail_reg;

    always_comb
    begin
        unique case (ctrl.uop)
            U_MUL_SL:
            begin
                mul_a = MUL_A_W'(sin_reg);
                mul_b = MUL_B_W'(level_reg);
            end
            U_MUL_LO:
            begin
                mul_a = MUL_A_W'(prod_reg[LO_W-1:0]);
                mul_b = tailx;
            end
            U_MUL_HI:
            begin
                mul_a = MUL_A_W'(prod_reg[SL_W-1:LO_W]);
                mul_b = tailx;
            end
            U_ROUND:
            begin
                mul_a = MUL_A_W'(tail_reg);
                mul_b = MUL_B_W'(DECAY_Q16);
            end
            U_NOTE_MUL:
            begin
                mul_a = MUL_A_W'(a4_reg);
                mul_b = MUL_B_W'(NOTE_RATIO[note_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // sample magnitude: round half up, saturate, then apply sign
    assign rnd        = {1'b0, acc_reg} + ROUND_HALF;
    assign mag_full   = rnd >> ROUND_SH;
    assign mag        = (mag_full > MAG_MAX) ? MAG_MAX[SAMPLE_BITS-1:0]
                                             : mag_full[SAMPLE_BITS-1:0];
    assign sample_val = neg_reg ? (SAMPLE_BITS'(0) - mag) : mag;

    assign dec_sum  = mul_reg + MUL_P_W'(32768);
    assign dec_tail = dec_sum[16 +: TAIL_W];

    // note step: round half up at the octave shift, saturate to the phase width
    assign step_rnd = {1'b0, mul_reg} + (NSTEP_W'(1) << (shift_reg - 1'b1));
    assign step_shr = step_rnd >> shift_reg;
    assign step_sat = (|step_shr[NSTEP_W-1:PHASE_BITS]) ? '1 : step_shr[PHASE_BITS-1:0];

    always_comb
    begin
        a4_next         = a4_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        level_next      = level_reg;
        tail_next       = tail_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        allow_next      = allow_reg;
        sin_next        = sin_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        mul_next        = mul_reg;
        acc_next        = acc_reg;
        shift_next      = shift_reg;
        smp_val_next    = smp_val_reg;
        out_sample_next = out_sample_reg;
        out_active_next = out_active_reg;
        out_valid_next  = out_valid_reg;

        if (cfg.valid && cfg.ready)
        begin
            a4_next = cfg.a4_phase_increment;
        end
        if (in_xfer)
        begin
            note_next  = req.note;
            vel_next   = req.velocity;
            allow_next = req.allow_tail_off;
        end
        if (smp.valid && smp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.uop)
            U_NOP:
            begin
            end
            U_SIN_RD:
            begin
                sin_next = pos[QB] ? SINE_PEAK : SINE_ROM[pos[QB-1:0]];
                neg_next = quad[1];
            end
            U_MUL_SL:
            begin
                mul_next = mul_prod;
            end
            U_LATCH_PROD:
            begin
                prod_next = mul_reg[SL_W-1:0];
            end
            U_MUL_LO:
            begin
                mul_next = mul_prod;
            end
            U_MUL_HI:
            begin
                acc_next = ACC_W'(mul_reg);
                mul_next = mul_prod;
            end
            U_ACC_ADD:
            begin
                acc_next = acc_reg + (ACC_W'(mul_reg) << LO_W);
            end
            U_ROUND:
            begin
                smp_val_next = sample_val;
                mul_next     = mul_prod;
            end
            U_DECAY:
            begin
                phase_next = phase_reg + step_reg;
                if (tail_reg != '0)
                begin
                    tail_next = dec_tail;
                    if (dec_tail <= STOP_LEVEL_Q16)
                    begin
                        step_next = '0;
                    end
                end
            end
            U_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_sample_next = smp_val_reg;
                out_active_next = (step_reg != '0);
            end
            U_ZERO:
            begin
                smp_val_next = '0;
            end
            U_NOTE_MUL:
            begin
                mul_next   = mul_prod;
                phase_next = '0;
                tail_next  = '0;
                level_next = vel_reg;
                shift_next = NOTE_SHIFT[note_reg];
            end
            U_NOTE_STEP:
            begin
                step_next = step_sat;
            end
            U_NOTE_OFF:
            begin
                if (allow_reg)
                begin
                    if (tail_reg == '0)
                    begin
                        tail_next = TAIL_ONE_Q16;
                    end
                end
                else
                begin
                    step_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a4_reg        <= A4_RESET;
            phase_reg     <= '0;
            step_reg      <= '0;
            level_reg     <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a4_reg        <= a4_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            level_reg     <= level_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg       <= note_next;
        vel_reg        <= vel_next;
        allow_reg      <= allow_next;
        sin_reg        <= sin_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        mul_reg        <= mul_next;
        acc_reg        <= acc_next;
        shift_reg      <= shift_next;
        smp_val_reg    <= smp_val_next;
        out_sample_reg <= out_sample_next;
        out_active_reg <= out_active_next;
    end

    // a sounding voice never carries a tail at or below the stop level
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> (tail_reg == '0 || tail_reg > STOP_LEVEL_Q16))
        else $error("voice sounding with a finished tail");

    assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= TAIL_ONE_Q16)
        else $error("tail above 1.0");

    // a sample appears only from the emit step of a tick program
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.uop == U_EMIT))
        else $error("sample valid without emit step");

    // emit never overwrites a sample still waiting for transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.uop == U_EMIT) |-> !out_valid_reg)
        else $error("emit while output register full");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> ctrl.busy)
        else $error("request transfer did not start a program");

endmodule

`default_nettype wire

FILE: sv/svtd_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none

module svtd_seq (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire [svtd_pkg::REQ_W-1:0] req_type,
    input  svtd_pkg::seq_status_t    status,
    output svtd_pkg::seq_ctrl_t      ctrl
);
    import svtd_pkg::*;

    localparam logic [PC_W-1:0] PC_TICK     = 4'd0;
    localparam logic [PC_W-1:0] PC_WAIT     = 4'd8;
    localparam logic [PC_W-1:0] PC_ZERO     = 4'd10;
    localparam logic [PC_W-1:0] PC_NOTE_ON  = 4'd11;
    localparam logic [PC_W-1:0] PC_NOTE_OFF = 4'd13;
    localparam logic [PC_W-1:0] PC_IGNORE   = 4'd14;
    localparam logic [PC_W-1:0] PC_NONE     = 4'd0;

    localparam uword_t UCODE [UCODE_DEPTH] = '{
        '{U_SIN_RD,     C_SILENT,   PC_ZERO, 1'b0},  // 0  tick entry
        '{U_MUL_SL,     C_NEXT,     PC_NONE, 1'b0},  // 1  sin * level
        '{U_LATCH_PROD, C_NEXT,     PC_NONE, 1'b0},  // 2
        '{U_MUL_LO,     C_NEXT,     PC_NONE, 1'b0},  // 3  low half * tail
        '{U_MUL_HI,     C_NEXT,     PC_NONE, 1'b0},  // 4  high half * tail
        '{U_ACC_ADD,    C_NEXT,     PC_NONE, 1'b0},  // 5
        '{U_ROUND,      C_NEXT,     PC_NONE, 1'b0},  // 6  round, tail * decay
        '{U_DECAY,      C_NEXT,     PC_NONE, 1'b0},  // 7  phase, tail update
        '{U_NOP,        C_OUT_FULL, PC_WAIT, 1'b0},  // 8  hold for output reg
        '{U_EMIT,       C_NEXT,     PC_NONE, 1'b1},  // 9
        '{U_ZERO,       C_ALWAYS,   PC_WAIT, 1'b0},  // 10 silent tick
        '{U_NOTE_MUL,   C_NEXT,     PC_NONE, 1'b0},  // 11 note-on entry
        '{U_NOTE_STEP,  C_NEXT,     PC_NONE, 1'b1},  // 12
        '{U_NOTE_OFF,   C_NEXT,     PC_NONE, 1'b1},  // 13 note-off entry
        '{U_NOP,        C_NEXT,     PC_NONE, 1'b1}   // 14 unknown request
    };

    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] entry;
    logic            taken;
    uword_t          word;

    assign word = UCODE[pc_reg];

    always_comb
    begin
        unique case (req_type)
            REQ_TICK:     entry = PC_TICK;
            REQ_NOTE_ON:  entry = PC_NOTE_ON;
            REQ_NOTE_OFF: entry = PC_NOTE_OFF;
            default:      entry = PC_IGNORE;
        endcase
    end

    always_comb
    begin
        unique case (word.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_SILENT:   taken = status.silent;
            C_OUT_FULL: taken = status.out_full;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = entry;
            end
        end
        else if (taken)
        begin
            pc_next = word.tgt;
        end
        else if (word.last)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_TICK;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.uop  = busy_reg ? word.uop : U_NOP;
    assign ctrl.busy = busy_reg;

endmodule

`default_nettype wire
